[rtl/core/tecp_pkg.sv]
package tecp_pkg;

    // Fixed widths of the payload and the configuration port.
    localparam int DATA_W    = 64;
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_W = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_W   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_H   = 3'd4;

    // Texture formats.
    typedef enum logic [2:0] {
        FMT_DXT1       = 3'd0,
        FMT_DXT3       = 3'd1,
        FMT_DXT5       = 3'd2,
        FMT_DXT5_YCOCG = 3'd3,
        FMT_A8         = 3'd4,
        FMT_RGB8       = 3'd5,
        FMT_RGBA8      = 3'd6,
        FMT_ARGB8      = 3'd7
    } fmt_t;

    // Size of one format block.
    typedef enum logic [1:0] {
        BW_1  = 2'd0,
        BW_4  = 2'd1,
        BW_8  = 2'd2,
        BW_16 = 2'd3
    } bw_t;

    // Where the data of a texture block comes from.
    typedef enum logic [1:0] {
        KIND_IMAGE = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_LINE  = 2'd2
    } kind_t;

    localparam fmt_t              RESET_FMT = FMT_RGBA8;
    localparam logic [DIM_W-1:0]  RESET_DIM = 13'd1;

    // One classified texture block, passed from the front to the back.
    typedef struct packed {
        logic [DATA_W-1:0]  lo;
        logic [DATA_W-1:0]  hi;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        kind_t              kind;
        logic               last;
        logic               edge_update;
    } item_t;

    // Block size of a format.
    function automatic bw_t block_width(input fmt_t fmt);
        bw_t bw;
        unique case (fmt)
            FMT_DXT1:                          bw = BW_8;
            FMT_DXT3, FMT_DXT5, FMT_DXT5_YCOCG: bw = BW_16;
            FMT_A8:                            bw = BW_1;
            default:                           bw = BW_4;
        endcase
        return bw;
    endfunction

endpackage

[rtl/core/tecp_if.sv]
// Input slot channel: one source block per texture block.
interface tecp_slot_if import tecp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] block_low;
    logic [DATA_W-1:0] block_high;

    modport source (output valid, block_low, block_high, input ready);
    modport sink (input valid, block_low, block_high, output ready);
endinterface

// Result channel: one texture block per transfer.
interface tecp_block_if import tecp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  out_low;
    logic [DATA_W-1:0]  out_high;
    logic [COORD_W-1:0] block_column;
    logic [COORD_W-1:0] block_row;
    logic [1:0]         source_kind;
    logic               frame_last;

    modport source (output valid, out_low, out_high, block_column, block_row,
                    source_kind, frame_last, input ready);
    modport sink (input valid, out_low, out_high, block_column, block_row,
                  source_kind, frame_last, output ready);
endinterface

// Configuration write channel.
interface tecp_cfg_if import tecp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/texture_edge_clamp_padder_top.sv]
// A transferred slot is stored in the queue and then in the output register before its result
// can transfer on the result channel; result stalls can hold it longer.
// Throughput: one texture block per cycle when results do not stall, bounded by the single
// line-store access per block. A configuration write holds the slot channel for one cycle
// while the block grid refreshes. Reset (rst_n low, asynchronous) clears position, edge block,
// queue and output, and sets format rgba8 and all sizes to one; the line store is not cleared.
module texture_edge_clamp_padder_top import tecp_pkg::*;
#(
    parameter int MAX_TEXTURE_SIZE = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    tecp_cfg_if.sink     cfg,
    tecp_slot_if.sink    slot,
    tecp_block_if.source block
);

    localparam int IW      = $clog2(MAX_TEXTURE_SIZE);
    localparam int ITEM_W  = $bits(item_t);
    localparam int ENTRY_W = ITEM_W + IW;

    item_t               front_item;
    logic [IW-1:0]       front_index;
    logic                front_valid;
    logic                front_ready;

    logic [ENTRY_W-1:0]  queue_out;
    item_t               back_item;
    logic [IW-1:0]       back_index;
    logic                back_valid;
    logic                back_ready;

    // Front: configuration, position counting and classification.
    tecp_front #(
        .MAX_TEXTURE_SIZE (MAX_TEXTURE_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .slot       (slot),
        .item       (front_item),
        .line_index (front_index),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    // Short queue between the front and the back.
    tecp_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   ({front_index, front_item}),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (queue_out)
    );

    assign back_item  = queue_out[ITEM_W-1:0];
    assign back_index = queue_out[ENTRY_W-1:ITEM_W];

    // Back: edge register, line store and output register.
    tecp_back #(
        .MAX_TEXTURE_SIZE (MAX_TEXTURE_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .line_index (back_index),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .block      (block)
    );

endmodule

[rtl/core/tecp_front.sv]
module tecp_front import tecp_pkg::*;
#(
    parameter int MAX_TEXTURE_SIZE = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    tecp_cfg_if.sink                            cfg,
    tecp_slot_if.sink                           slot,
    output item_t                               item,
    output logic [$clog2(MAX_TEXTURE_SIZE)-1:0] line_index,
    output logic                                item_valid,
    input  logic                                item_ready
);

    localparam int CW  = $clog2(MAX_TEXTURE_SIZE);
    localparam int DW  = $clog2(MAX_TEXTURE_SIZE + 1);
    localparam int NW  = DW + 1;
    localparam int EW0 = $clog2(3 * MAX_TEXTURE_SIZE + 4);
    localparam int EW  = (EW0 > DIM_W) ? EW0 : DIM_W;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_TEXTURE_SIZE);

    // Clamp a dimension to one up to a limit.
    function automatic logic [EW-1:0] clamp_dim(input logic [EW-1:0] v,
                                                 input logic [EW-1:0] hi);
        logic [EW-1:0] r;
        if (v == '0)
        begin
            r = EW'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Number of block columns that cover a width in pixels.
    function automatic logic [EW-1:0] cols_of(input logic [EW-1:0] w, input fmt_t fmt);
        logic [EW-1:0] w1;
        logic [EW-1:0] r;
        w1 = w + EW'(1);
        if (fmt <= FMT_DXT5_YCOCG)
        begin
            r = (w + EW'(3)) >> 2;
        end
        else if (fmt == FMT_RGB8)
        begin
            r = (w1 + (w1 << 1)) >> 2;
        end
        else
        begin
            r = w;
        end
        return r;
    endfunction

    // Number of block rows that cover a height in pixels.
    function automatic logic [EW-1:0] rows_of(input logic [EW-1:0] h, input fmt_t fmt);
        logic [EW-1:0] r;
        if (fmt <= FMT_DXT5_YCOCG)
        begin
            r = (h + EW'(3)) >> 2;
        end
        else
        begin
            r = h;
        end
        return r;
    endfunction

    fmt_t             fmt_reg;
    logic [DIM_W-1:0] img_w_reg;
    logic [DIM_W-1:0] img_h_reg;
    logic [DIM_W-1:0] tex_w_reg;
    logic [DIM_W-1:0] tex_h_reg;
    logic             stale_reg;

    logic [DW-1:0]    cols_reg;
    logic [DW-1:0]    rows_reg;
    logic [DW-1:0]    img_cols_reg;
    logic [DW-1:0]    img_rows_reg;
    bw_t              bw_reg;

    logic [DW-1:0]    cols_next;
    logic [DW-1:0]    rows_next;
    logic [DW-1:0]    img_cols_next;
    logic [DW-1:0]    img_rows_next;

    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    row_reg;
    logic [CW-1:0]    col_next;
    logic [CW-1:0]    row_next;

    logic             cfg_write;
    logic             accept;

    logic [NW-1:0]    col_eff;
    logic [NW-1:0]    row_eff;
    logic [NW-1:0]    row_wrap;
    logic [NW-1:0]    col_inc;
    logic [NW-1:0]    row_inc;
    logic             col_over;
    logic             end_row;
    logic             end_frame;
    logic             in_rows;
    logic             in_cols;
    logic [DATA_W-1:0] data_lo;
    logic [DATA_W-1:0] data_hi;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= RESET_FMT;
            img_w_reg <= RESET_DIM;
            img_h_reg <= RESET_DIM;
            tex_w_reg <= RESET_DIM;
            tex_h_reg <= RESET_DIM;
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                CFG_FORMAT:  fmt_reg   <= fmt_t'(cfg.data[2:0]);
                CFG_IMAGE_W: img_w_reg <= cfg.data;
                CFG_IMAGE_H: img_h_reg <= cfg.data;
                CFG_TEX_W:   tex_w_reg <= cfg.data;
                CFG_TEX_H:   tex_h_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    // Block grid derived from the configuration.
    always_comb
    begin
        logic [EW-1:0] tw;
        logic [EW-1:0] th;
        logic [EW-1:0] iw;
        logic [EW-1:0] ih;
        tw            = clamp_dim(EW'(tex_w_reg), MAX_E);
        th            = clamp_dim(EW'(tex_h_reg), MAX_E);
        iw            = clamp_dim(EW'(img_w_reg), tw);
        ih            = clamp_dim(EW'(img_h_reg), th);
        cols_next     = DW'(cols_of(tw, fmt_reg));
        rows_next     = DW'(rows_of(th, fmt_reg));
        img_cols_next = DW'(cols_of(iw, fmt_reg));
        img_rows_next = DW'(rows_of(ih, fmt_reg));
    end

    // The grid register follows the configuration in the cycle after it changes.
    always_ff @(posedge clk)
    begin
        cols_reg     <= cols_next;
        rows_reg     <= rows_next;
        img_cols_reg <= img_cols_next;
        img_rows_reg <= img_rows_next;
        bw_reg       <= block_width(fmt_reg);
    end

    // Slots are held back for the cycle in which the grid is being refreshed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= 1'b1;
        end
        else
        begin
            stale_reg <= cfg_write;
        end
    end

    assign item_valid = slot.valid && !stale_reg;
    assign slot.ready = item_ready && !stale_reg;
    assign accept     = slot.valid && slot.ready;

    // Position of this slot, wrapped onto the current grid, and the next position.
    always_comb
    begin
        col_over  = NW'(col_reg) >= NW'(cols_reg);
        col_eff   = col_over ? '0 : NW'(col_reg);
        row_wrap  = NW'(row_reg) + NW'(col_over);
        row_eff   = (row_wrap >= NW'(rows_reg)) ? '0 : row_wrap;
        col_inc   = col_eff + NW'(1);
        row_inc   = row_eff + NW'(1);
        end_row   = col_inc >= NW'(cols_reg);
        end_frame = row_inc >= NW'(rows_reg);
        if (end_row)
        begin
            col_next = '0;
            row_next = end_frame ? '0 : CW'(row_inc);
        end
        else
        begin
            col_next = CW'(col_inc);
            row_next = CW'(row_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Bytes beyond the format block are dropped.
    always_comb
    begin
        unique case (bw_reg)
            BW_1:
            begin
                data_lo = {56'd0, slot.block_low[7:0]};
                data_hi = '0;
            end
            BW_4:
            begin
                data_lo = {32'd0, slot.block_low[31:0]};
                data_hi = '0;
            end
            BW_8:
            begin
                data_lo = slot.block_low;
                data_hi = '0;
            end
            BW_16:
            begin
                data_lo = slot.block_low;
                data_hi = slot.block_high;
            end
            default:
            begin
                data_lo = slot.block_low;
                data_hi = '0;
            end
        endcase
    end

    // Classification of the slot.
    always_comb
    begin
        in_rows = row_eff < NW'(img_rows_reg);
        in_cols = col_eff < NW'(img_cols_reg);
        item.lo          = data_lo;
        item.hi          = data_hi;
        item.column      = COORD_W'(col_eff);
        item.row         = COORD_W'(row_eff);
        item.last        = end_row && end_frame;
        item.edge_update = in_rows && in_cols && (col_inc == NW'(img_cols_reg));
        if (!in_rows)
        begin
            item.kind = KIND_LINE;
        end
        else if (in_cols)
        begin
            item.kind = KIND_IMAGE;
        end
        else
        begin
            item.kind = KIND_EDGE;
        end
    end

    assign line_index = CW'(col_eff);

    // The image area never reaches past the texture.
    grid_fits: assert property (@(posedge clk) disable iff (!rst_n)
        !stale_reg |-> (img_cols_reg <= cols_reg) && (img_rows_reg <= rows_reg))
        else $error("image grid larger than texture grid");

    // A configuration write blocks the slot channel for one cycle.
    cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !slot.ready)
        else $error("slot taken while grid refreshes");

    // The final block of a frame returns the position to the origin.
    frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last) |=> (col_reg == '0) && (row_reg == '0))
        else $error("position not at origin after last block");

endmodule

[rtl/core/tecp_fifo.sv]
module tecp_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;
    logic [NW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != NW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill-level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/core/tecp_back.sv]
module tecp_back import tecp_pkg::*;
#(
    parameter int MAX_TEXTURE_SIZE = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  item_t                               item,
    input  logic [$clog2(MAX_TEXTURE_SIZE)-1:0] line_index,
    input  logic                                item_valid,
    output logic                                item_ready,
    tecp_block_if.source                        block
);

    logic [2*DATA_W-1:0] line_mem [MAX_TEXTURE_SIZE];
    logic [2*DATA_W-1:0] line_rd_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   edge_lo_reg;
    logic [DATA_W-1:0]   edge_hi_reg;
    logic [DATA_W-1:0]   data_lo_reg;
    logic [DATA_W-1:0]   data_hi_reg;
    logic [COORD_W-1:0]  column_reg;
    logic [COORD_W-1:0]  row_reg;
    kind_t               kind_reg;
    logic                last_reg;

    logic                advance;
    logic                take;
    logic [DATA_W-1:0]   src_lo;
    logic [DATA_W-1:0]   src_hi;

    // The output register moves when empty or when its transfer completes.
    assign advance    = !out_valid_reg || block.ready;
    assign item_ready = advance;
    assign take       = item_valid && advance;

    // Data for image and edge blocks.
    always_comb
    begin
        unique case (item.kind)
            KIND_IMAGE:
            begin
                src_lo = item.lo;
                src_hi = item.hi;
            end
            KIND_EDGE:
            begin
                src_lo = edge_lo_reg;
                src_hi = edge_hi_reg;
            end
            default:
            begin
                src_lo = item.lo;
                src_hi = item.hi;
            end
        endcase
    end

    // Last image block of the current row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_lo_reg <= '0;
            edge_hi_reg <= '0;
        end
        else if (take && (item.kind == KIND_IMAGE) && item.edge_update)
        begin
            edge_lo_reg <= item.lo;
            edge_hi_reg <= item.hi;
        end
    end

    // Line store write: every block inside the image rows.
    always_ff @(posedge clk)
    begin
        if (take && (item.kind != KIND_LINE))
        begin
            line_mem[line_index] <= {src_hi, src_lo};
        end
    end

    // Line store read: blocks below the image.
    always_ff @(posedge clk)
    begin
        if (take && (item.kind == KIND_LINE))
        begin
            line_rd_reg <= line_mem[line_index];
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_lo_reg <= src_lo;
            data_hi_reg <= src_hi;
            column_reg  <= item.column;
            row_reg     <= item.row;
            kind_reg    <= item.kind;
            last_reg    <= item.last;
        end
    end

    assign block.valid        = out_valid_reg;
    assign block.out_low      = (kind_reg == KIND_LINE) ? line_rd_reg[DATA_W-1:0] : data_lo_reg;
    assign block.out_high     = (kind_reg == KIND_LINE) ? line_rd_reg[2*DATA_W-1:DATA_W]
                                                        : data_hi_reg;
    assign block.block_column = column_reg;
    assign block.block_row    = row_reg;
    assign block.source_kind  = kind_reg;
    assign block.frame_last   = last_reg;

    // A block taken from the queue is offered in the next cycle.
    taken_shown: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> block.valid)
        else $error("taken block not offered");

    // The row's last image block is captured as the edge.
    edge_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (item.kind == KIND_IMAGE) && item.edge_update)
        |=> (edge_lo_reg == $past(item.lo)) && (edge_hi_reg == $past(item.hi)))
        else $error("edge block not captured");

    // A right-edge block carries the edge held when it was taken.
    edge_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (item.kind == KIND_EDGE))
        |=> (data_lo_reg == $past(edge_lo_reg)) && (data_hi_reg == $past(edge_hi_reg)))
        else $error("edge repeat mismatch");

endmodule
